>>> rtl/frm_pkg.sv
// Shared types and constants for the four-lane run merge unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package frm_pkg;

	localparam int LANES   = 4;
	localparam int LANE_W  = 2;
	localparam int VALUE_W = 16;
	localparam int CNT_W   = 8;
	localparam int RUN_MAX = 255;
	localparam int CFG_IDX_W = 3;
	localparam int TDATA_W = 24;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_VALUE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LANE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_LEN0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_LEN3    = 3'd4;

	localparam logic [LANE_W-1:0] OUTPUT_LANE_RST = 2'd3;

	typedef struct packed {
		logic               start;
		logic [LANE_W-1:0]  lane;
		logic [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [LANE_W-1:0]             output_lane;
		logic [LANES-1:0][CNT_W-1:0]   run_len;
	} cfg_t;

	typedef struct packed {
		logic [VALUE_W-1:0] merged_value;
		logic [LANE_W-1:0]  source_lane;
		logic               refill_wanted;
		logic               round_done;
	} res_t;

	function automatic logic [CNT_W-1:0] run_limit(input logic [CNT_W-1:0] len);
		return (32'(len) > RUN_MAX) ? CNT_W'(RUN_MAX) : len;
	endfunction

endpackage
`default_nettype wire

>>> rtl/frm_front.sv
// Front end: accepts stream items, tags them as round start or lane value,
// and holds them in a two-entry queue for the back end. Uses frm_pkg.
`default_nettype none
module frm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [frm_pkg::TDATA_W-1:0]       s_tdata,
	input  logic [0:0]                        s_tuser,
	output logic                              q_valid,
	input  logic                              q_ready,
	output frm_pkg::item_t                    q_item
);
	import frm_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      item_in;

	assign s_tready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign push     = s_tvalid && s_tready;
	assign pop      = q_valid && q_ready;
	assign q_item   = entry_q[rd_ptr_q];

	always_comb begin
		item_in.start = (s_tuser[0] == KIND_START);
		item_in.lane  = s_tdata[LANE_W-1:0];
		item_in.value = s_tdata[LANE_W +: VALUE_W];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/frm_back.sv
// Back end: lane heads, emission counters and exhaustion flags; picks the
// smallest head each cycle and drives a registered result. Uses frm_pkg.
`default_nettype none
module frm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  frm_pkg::cfg_t   cfg,
	input  logic            q_valid,
	output logic            q_ready,
	input  frm_pkg::item_t  q_item,
	output logic            res_valid,
	input  logic            res_ready,
	output frm_pkg::res_t   res
);
	import frm_pkg::*;

	logic [VALUE_W-1:0]            head_q [LANES];
	logic [LANES-1:0]              full_q;
	logic [LANES-1:0]              exh_q;
	logic [LANES-1:0][CNT_W-1:0]   cnt_q;
	logic                          busy_q;
	logic                          res_valid_q;
	res_t                          res_q;

	logic                 can_out;
	logic                 take;
	logic                 eval;
	logic                 emit;
	logic [LANES-1:0]     is_out;
	logic [LANES-1:0]     active;
	logic                 wr;
	logic [LANES-1:0]     wr_mask;
	logic [LANES-1:0]     full_e;
	logic [VALUE_W-1:0]   head_e [LANES];
	logic                 any;
	logic                 ready;
	logic                 found;
	logic [LANE_W-1:0]    best;
	logic [VALUE_W-1:0]   best_v;
	logic [LANES-1:0]     best_mask;
	logic [CNT_W-1:0]     limit;
	logic [CNT_W:0]       cnt_inc;
	logic                 exhaust;
	logic                 done;

	assign can_out = !res_valid_q || res_ready;
	assign take    = !busy_q && q_valid && can_out;
	assign q_ready = take;
	assign eval    = (take && !q_item.start) || (busy_q && can_out);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			is_out[i] = (cfg.output_lane == LANE_W'(i));
		end
		active  = ~exh_q & ~is_out;
		wr      = take && !q_item.start && active[q_item.lane] && !full_q[q_item.lane];
		wr_mask = wr ? (LANES'(1) << q_item.lane) : '0;
		full_e  = full_q | wr_mask;
		for (int i = 0; i < LANES; i++) begin
			head_e[i] = wr_mask[i] ? q_item.value : head_q[i];
		end
		any   = |active;
		ready = ((active & ~full_e) == '0);

		found  = 1'b0;
		best   = '0;
		best_v = '0;
		for (int i = 0; i < LANES; i++) begin
			if (active[i] && (!found || head_e[i] < best_v)) begin
				best   = LANE_W'(i);
				best_v = head_e[i];
				found  = 1'b1;
			end
		end
		best_mask = LANES'(1) << best;

		limit   = run_limit(cfg.run_len[best]);
		cnt_inc = {1'b0, cnt_q[best]} + (CNT_W+1)'(1);
		exhaust = (cnt_inc >= {1'b0, limit});
		done    = ((active & ~(exhaust ? best_mask : '0)) == '0);
		emit    = eval && any && ready;
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			head_q[q_item.lane] <= q_item.value;
		end
		if (can_out && emit) begin
			res_q.merged_value <= best_v;
			res_q.source_lane  <= best;
			res_q.refill_wanted <= !exhaust;
			res_q.round_done   <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q      <= '0;
			exh_q       <= '0;
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take && q_item.start) begin
				full_q <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b0;
				for (int i = 0; i < LANES; i++) begin
					exh_q[i] <= is_out[i] || (run_limit(cfg.run_len[i]) == '0);
				end
			end else begin
				full_q <= full_e & ~(emit ? best_mask : '0);
				if (emit) begin
					cnt_q[best] <= cnt_inc[CNT_W-1:0];
					if (exhaust) exh_q[best] <= 1'b1;
				end
				if (eval) busy_q <= emit && exhaust;
			end
			if (can_out) res_valid_q <= emit;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

>>> rtl/four_lane_run_merge_unit.sv
// Four-lane run merge unit: merges sorted runs from three lanes into one stream.
// Throughput: one item per cycle unless the back end is busy or the output stalls; a value
// that releases results holds the back end until they are out, as the merge engine
// emits one result a cycle and rechecks the heads once after every exhaustion.
// Reset (arst_n low): config to defaults, queue, flags and counters cleared.
// Instantiates frm_front and frm_back; uses frm_pkg.
`default_nettype none
module four_lane_run_merge_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [frm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [frm_pkg::CNT_W-1:0]          cfg_wdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [frm_pkg::TDATA_W-1:0]        s_tdata,  // lane, value, zero pad
	input  logic [0:0]                         s_tuser,  // kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [frm_pkg::TDATA_W-1:0]        m_tdata,  // merged_value, source_lane, pad
	output logic [0:0]                         m_tuser,  // refill_wanted
	output logic                               m_tlast   // round_done
);
	import frm_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;
	res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_lane <= OUTPUT_LANE_RST;
			cfg_q.run_len     <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_idx == CFG_OUTPUT_LANE) begin
				cfg_q.output_lane <= cfg_wdata[LANE_W-1:0];
			end else if (cfg_idx inside {[CFG_RUN_LEN0:CFG_RUN_LEN3]}) begin
				cfg_q.run_len[LANE_W'(cfg_idx - CFG_RUN_LEN0)] <= cfg_wdata;
			end
		end
	end

	frm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	frm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata    = {(TDATA_W-VALUE_W-LANE_W)'(0), res.source_lane, res.merged_value};
	assign m_tuser[0] = res.refill_wanted;
	assign m_tlast    = res.round_done;

endmodule
`default_nettype wire

>>> sim/tb_four_lane_run_merge_unit.sv
// Self-checking testbench for four_lane_run_merge_unit: streams round starts and lane values,
// predicts the merged output per accepted item and compares every result field by field.
// Depends on rtl/frm_pkg.sv and rtl/four_lane_run_merge_unit.sv.
`timescale 1ns / 100ps
module tb_four_lane_run_merge_unit;
	import frm_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int ITEM_TARGET  = 470;
	localparam int MAX_PRINTS   = 20;

	typedef struct packed {
		logic               kind;
		logic [LANE_W-1:0]  lane;
		logic [VALUE_W-1:0] value;
	} stim_t;

	typedef struct packed {
		logic [LANE_W-1:0]             out_lane;
		logic [LANES-1:0][CNT_W-1:0]   run_len;
		logic [LANES-1:0][VALUE_W-1:0] head;
		logic [LANES-1:0]              full;
		logic [LANES-1:0]              exh;
		logic [LANES-1:0][15:0]        emitted;
	} merge_state_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [CNT_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata   = '0;
	logic [0:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [0:0]           m_tuser;
	logic                 m_tlast;

	stim_t        pending_items[$];
	res_t         merged_expect[$];
	merge_state_t plan_st;
	merge_state_t pred_st;
	stim_t        cur_item;
	res_t [LANES-1:0] res_buf;
	int           n_res;
	int           gen_last[LANES];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	logic hold_go = 1'b0;
	int  hold_cnt;
	wire hold_active = hold_go && (hold_cnt < HOLD_CYCLES);

	int errors;
	int item_total;
	int results_seen;
	int starts_seen;
	int cfg_writes;
	int phase;

	four_lane_run_merge_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#(4_000_000);
		$display("Timeout with %0d results still expected", merged_expect.size());
		$display("Test completed with failures");
		$finish;
	end

	function automatic bit lane_live(merge_state_t st, int i);
		return !st.exh[i] && (LANE_W'(i) != st.out_lane);
	endfunction

	function automatic int merge_step(inout merge_state_t st, input stim_t it,
		output res_t [LANES-1:0] res);
		int  n;
		int  best;
		bit  any;
		bit  ready;
		bit  refill;
		bit  done;
		n = 0;
		res = '0;
		if (it.kind == KIND_START) begin
			for (int i = 0; i < LANES; i++) begin
				st.full[i]    = 1'b0;
				st.emitted[i] = '0;
				st.exh[i]     = (LANE_W'(i) == st.out_lane) || (st.run_len[i] == '0);
			end
			return 0;
		end
		if (lane_live(st, it.lane) && !st.full[it.lane]) begin
			st.head[it.lane] = it.value;
			st.full[it.lane] = 1'b1;
		end
		while (n < LANES) begin
			any   = 1'b0;
			ready = 1'b1;
			best  = 0;
			for (int i = 0; i < LANES; i++) begin
				if (!lane_live(st, i))
					continue;
				if (!st.full[i]) begin
					ready = 1'b0;
					break;
				end
				if (!any || st.head[i] < st.head[best])
					best = i;
				any = 1'b1;
			end
			if (!any || !ready)
				break;
			st.full[best] = 1'b0;
			st.emitted[best] = st.emitted[best] + 16'd1;
			refill = st.emitted[best] < 16'(st.run_len[best]);
			if (!refill)
				st.exh[best] = 1'b1;
			done = 1'b1;
			for (int i = 0; i < LANES; i++)
				if (lane_live(st, i))
					done = 1'b0;
			res[n] = '{merged_value: st.head[best], source_lane: LANE_W'(best),
				refill_wanted: refill, round_done: done};
			n++;
			if (refill)
				break;
		end
		return n;
	endfunction

	function automatic stim_t mk(logic kind, int lane, int value);
		stim_t it;
		it.kind  = kind;
		it.lane  = LANE_W'(lane);
		it.value = VALUE_W'(value);
		return it;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < MAX_PRINTS)
			$display("MISMATCH %s: got %0h want %0h at result %0d", what, got, want,
				results_seen);
		errors++;
	endtask

	task automatic push_item(input stim_t it);
		res_t [LANES-1:0] scratch;
		pending_items.push_back(it);
		void'(merge_step(plan_st, it, scratch));
		item_total++;
	endtask

	task automatic push_value(input int lane);
		int v;
		v = gen_last[lane] + (($urandom_range(0, 2) == 0) ? $urandom_range(0, 2)
			: $urandom_range(0, 3000));
		if (v > 65535)
			v = 65535;
		gen_last[lane] = v;
		push_item(mk(KIND_VALUE, lane, v));
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_OUTPUT_LANE) begin
			plan_st.out_lane = data[LANE_W-1:0];
			pred_st.out_lane = data[LANE_W-1:0];
		end else begin
			plan_st.run_len[LANE_W'(idx - CFG_RUN_LEN0)] = data;
			pred_st.run_len[LANE_W'(idx - CFG_RUN_LEN0)] = data;
		end
		cfg_writes++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || merged_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one merge round: mostly refills for the lanes the block waits on, some noise
	task automatic gen_round(input int budget, input bit with_start);
		int open_lanes[$];
		if (with_start) begin
			push_item(mk(KIND_START, $urandom_range(0, 3), $urandom_range(0, 65535)));
			for (int i = 0; i < LANES; i++)
				gen_last[i] = ($urandom_range(0, 7) == 0) ? $urandom_range(60000, 65535)
					: $urandom_range(0, 200);
		end
		for (int k = 0; k < budget; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				push_item(mk(($urandom_range(0, 7) == 0) ? KIND_START : KIND_VALUE,
					$urandom_range(0, 3), $urandom_range(0, 65535)));
			end else begin
				open_lanes.delete();
				for (int i = 0; i < LANES; i++)
					if (lane_live(plan_st, i) && !plan_st.full[i])
						open_lanes.push_back(i);
				if (open_lanes.size() == 0)
					break;
				push_value(open_lanes[$urandom_range(0, open_lanes.size() - 1)]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				n_res = merge_step(pred_st, cur_item, res_buf);
				for (int i = 0; i < n_res; i++)
					merged_expect.push_back(res_buf[i]);
				if (cur_item.kind == KIND_START)
					starts_seen++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= TDATA_W'({cur_item.value, cur_item.lane});
					s_tuser  <= cur_item.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_active)
			hold_cnt <= hold_cnt + 1;
	end

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (merged_expect.size() == 0) begin
					report_mismatch("unexpected result", int'(m_tdata[VALUE_W-1:0]), -1);
				end else begin
					want = merged_expect.pop_front();
					if (m_tdata[VALUE_W-1:0] != want.merged_value)
						report_mismatch("merged_value", int'(m_tdata[VALUE_W-1:0]),
							int'(want.merged_value));
					if (m_tdata[VALUE_W+LANE_W-1:VALUE_W] != want.source_lane)
						report_mismatch("source_lane", int'(m_tdata[VALUE_W+LANE_W-1:VALUE_W]),
							int'(want.source_lane));
					if (m_tuser[0] != want.refill_wanted)
						report_mismatch("refill_wanted", int'(m_tuser[0]),
							int'(want.refill_wanted));
					if (m_tlast != want.round_done)
						report_mismatch("round_done", int'(m_tlast), int'(want.round_done));
				end
				results_seen++;
			end
			m_tready <= !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		int big_lane;
		bit keep_round;
		errors       = 0;
		item_total   = 0;
		results_seen = 0;
		starts_seen  = 0;
		cfg_writes   = 0;
		plan_st          = '0;
		plan_st.out_lane = OUTPUT_LANE_RST;
		pred_st          = plan_st;
		for (int i = 0; i < LANES; i++)
			gen_last[i] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct <= 20;
		recv_idle_pct <= 68;

		// no round started yet: zero run lengths exhaust each lane on its first emit
		push_item(mk(KIND_VALUE, 0, 16'hFFFF));
		push_item(mk(KIND_VALUE, 3, 16'h1234));
		push_item(mk(KIND_VALUE, 1, 16'h0000));
		push_item(mk(KIND_VALUE, 0, 16'h0005));
		push_item(mk(KIND_VALUE, 2, 16'h0000));
		push_item(mk(KIND_VALUE, 1, 16'h0007));
		wait_drain();

		cfg_write(CFG_OUTPUT_LANE, 8'd0);
		cfg_write(CFG_RUN_LEN0 + 3'd0, 8'd5);
		cfg_write(CFG_RUN_LEN0 + 3'd1, 8'd255);
		cfg_write(CFG_RUN_LEN0 + 3'd2, 8'd0);
		cfg_write(CFG_RUN_LEN3, 8'd2);
		push_item(mk(KIND_START, 0, 0));
		push_item(mk(KIND_VALUE, 1, 16'h0000));
		push_item(mk(KIND_VALUE, 3, 16'h0000));
		push_item(mk(KIND_VALUE, 1, 16'hFFFF));
		push_item(mk(KIND_VALUE, 3, 16'h0001));
		push_item(mk(KIND_VALUE, 3, 16'hFFFF));
		push_item(mk(KIND_VALUE, 2, 16'h0009));
		push_item(mk(KIND_VALUE, 0, 16'h0009));
		push_item(mk(KIND_VALUE, 1, 16'hFFFF));
		push_item(mk(KIND_START, 3, 16'hFFFF));
		push_item(mk(KIND_VALUE, 3, 16'h8000));
		push_item(mk(KIND_VALUE, 1, 16'h7FFF));
		wait_drain();

		// output lane moves mid-round: lane 3 drops out at once
		cfg_write(CFG_OUTPUT_LANE, CNT_W'(OUTPUT_LANE_RST));
		push_item(mk(KIND_VALUE, 3, 16'h0010));
		push_item(mk(KIND_VALUE, 1, 16'h8001));
		push_item(mk(KIND_VALUE, 1, 16'h8002));
		wait_drain();

		phase = 0;
		while (item_total < ITEM_TARGET) begin
			if (item_total < 190) begin
				send_idle_pct <= 20;
				recv_idle_pct <= 68;
			end else if (item_total < 330) begin
				send_idle_pct <= 68;
				recv_idle_pct <= 20;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			keep_round = (phase > 0) && ($urandom_range(0, 4) == 0);
			if (phase == 1) begin
				// long output stall while the input keeps streaming
				cfg_write(CFG_OUTPUT_LANE, CNT_W'(OUTPUT_LANE_RST));
				for (int i = 0; i < 3; i++)
					cfg_write(CFG_RUN_LEN0 + CFG_IDX_W'(i), 8'd40);
				hold_go <= 1'b1;
				gen_round(130, 1'b1);
			end else if (phase == 4) begin
				big_lane = $urandom_range(0, 3);
				cfg_write(CFG_OUTPUT_LANE, CNT_W'((big_lane + 2) % LANES));
				for (int i = 0; i < LANES; i++)
					cfg_write(CFG_RUN_LEN0 + CFG_IDX_W'(i),
						(i == big_lane) ? 8'd255 : CNT_W'($urandom_range(0, 3)));
				gen_round(50, 1'b1);
			end else begin
				if ($urandom_range(0, 3) != 0)
					cfg_write(CFG_OUTPUT_LANE, CNT_W'($urandom_range(0, 3)));
				for (int i = 0; i < LANES; i++)
					if ($urandom_range(0, 3) != 0)
						cfg_write(CFG_RUN_LEN0 + CFG_IDX_W'(i),
							($urandom_range(0, 7) == 0) ? 8'd0 : CNT_W'($urandom_range(1, 6)));
				gen_round(40, !keep_round);
				if ($urandom_range(0, 1) != 0)
					gen_round(40, 1'b1);
			end
			wait_drain();
			phase++;
		end

		for (int w = 0; w < 5000 && (pending_items.size() != 0 || s_tvalid ||
			merged_expect.size() != 0); w++)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (merged_expect.size() != 0)
			report_mismatch("results never arrived", merged_expect.size(), 0);

		$display("Ran %0d items over %0d random phases: %0d round starts, %0d register writes",
			item_total, phase, starts_seen, cfg_writes);
		$display("Checked %0d merged results, %0d mismatches", results_seen, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
rtl/frm_pkg.sv
rtl/frm_front.sv
rtl/frm_back.sv
rtl/four_lane_run_merge_unit.sv
sim/tb_four_lane_run_merge_unit.sv
